// ===== rtl/core/uscf_pkg.sv =====
// Shared constants, month tables and types for the Unix seconds to calendar converter.
`timescale 1ns / 1ps

package uscf_pkg;

  // Input range that the every-fourth-year leap rule covers
  localparam logic [31:0] Start1972 = 32'd63072000;
  localparam logic [31:0] Start2100 = 32'd4102444800;

  // Field widths
  localparam int unsigned InW    = 32;
  localparam int unsigned DnumW  = 16;  // day number since 1972, below 46752
  localparam int unsigned TodW   = 17;  // second of the day, below 86400
  localparam int unsigned YoffW  = 7;   // year offset from 1972, below 128
  localparam int unsigned DoyW   = 9;   // zero-based day of the year
  localparam int unsigned MinTW  = 11;  // minute of the day, below 1440
  localparam int unsigned DataW  = 72;  // result tdata width, whole bytes

  localparam logic [11:0] BaseYear    = 12'd1972;
  localparam logic [6:0]  FatYearBias = 7'd8;  // 1980 - 1972

  // rel / 86400 is (rel >> 7) / 675, done as a multiply by a rounded-up reciprocal
  localparam int unsigned DayPreShift = 7;
  localparam int unsigned DayShift    = 41;
  localparam logic [31:0] RecipDay    = 32'd3257812231;
  localparam logic [16:0] SecsPerDay  = 17'd86400;

  // year offset = (4 * dnum) / 1461
  localparam int unsigned CycShift = 30;
  localparam logic [19:0] RecipCyc = 20'd734937;

  // tod / 3600 and tod / 60
  localparam int unsigned HourShift = 29;
  localparam logic [17:0] RecipHour = 18'd149131;
  localparam int unsigned MinShift  = 23;
  localparam logic [17:0] RecipMin  = 18'd139811;

  localparam logic [8:0]  DaysPerYear = 9'd365;

  // Zero-based day of the year on which each month starts
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    logic [8:0] adj;
    begin
      unique case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      // From March on, a leap year is one day further along.
      adj = (leap && (idx >= 4'd2) && (idx <= 4'd11)) ? 9'd1 : 9'd0;
      cum_days = base + adj;
    end
  endfunction

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } uscf_md_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [15:0] fat_time;
    logic [15:0] fat_date;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } uscf_res_t;

endpackage

// ===== rtl/core/uscf_month_lookup.sv =====
// Month and day of month from the zero-based day of the year.
`timescale 1ns / 1ps

module uscf_month_lookup (
  input  logic [8:0]         doy0_i,
  input  logic               leap_i,
  output uscf_pkg::uscf_md_t md_o
);
  import uscf_pkg::*;

  logic [3:0] month;
  logic [8:0] day_full;

  // The table rises monotonically, so the last start at or below the day wins.
  always_comb begin
    month = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (doy0_i >= cum_days(leap_i, 4'(k))) begin
        month = 4'(k + 1);
      end
    end
  end

  assign day_full   = doy0_i - cum_days(leap_i, month - 4'd1) + 9'd1;
  assign md_o.month = month;
  assign md_o.day   = day_full[4:0];

endmodule

// ===== rtl/core/unix_seconds_to_calendar_fields.sv =====
// Top level: Unix seconds count to civil date, time of day and FAT timestamp words.
`timescale 1ns / 1ps
// A result passes through the registers of stages 0 to 3 and then the output register.
// Throughput: one transaction per cycle while not stalled; the constant divisions are reciprocal
// multiplies, one multiply deep per stage, so the pipeline takes a new timestamp every cycle.
// A stall on the result side holds the whole pipeline, and s_axis_tready_o follows it.
// Reset (rst_ni low, asynchronous) clears only the stage valid flags; payloads are not reset.

module unix_seconds_to_calendar_fields (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [31:0]                s_axis_tdata_i,   // [31:0] unix_seconds
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
  // [37:32] second, [53:38] fat_date, [69:54] fat_time, [71:70] zero
  output logic [uscf_pkg::DataW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tuser_o    // [0] out_of_range
);
  import uscf_pkg::*;

  // The pipeline advances whenever the result register is free or being emptied.
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: input register. The range check and the division by 86400 follow.
  // ---------------------------------------------------------------------------
  logic             v0_q;
  logic [InW-1:0]   t_q;

  logic             oor0;
  logic [InW-1:0]   rel0;
  logic [56:0]      day_prod0;
  logic [DnumW-1:0] dnum0;

  assign oor0      = (t_q < Start1972) || (t_q >= Start2100);
  assign rel0      = t_q - Start1972;
  // A day is 128 times 675 seconds; drop the power of two first.
  assign day_prod0 = 57'(rel0[InW-1:DayPreShift]) * 57'(RecipDay);
  assign dnum0     = day_prod0[DayShift +: DnumW];

  // ---------------------------------------------------------------------------
  // Stage 1: second of the day and the year offset from the day number.
  // ---------------------------------------------------------------------------
  logic             v1_q;
  logic             oor1_q;
  logic [TodW-1:0]  rel1_q;
  logic [DnumW-1:0] dnum1_q;

  logic [32:0]      day_secs1;
  logic [TodW-1:0]  tod1;
  logic [37:0]      yr_prod1;
  logic [YoffW-1:0] yoff1;

  // The time of day is below 2^17, so the low bits of the subtraction are exact.
  assign day_secs1 = 33'(dnum1_q) * 33'(SecsPerDay);
  assign tod1      = rel1_q - day_secs1[TodW-1:0];
  // Whole years of 365.25 days: floor(4 * dnum / 1461).
  assign yr_prod1  = 38'({dnum1_q, 2'b00}) * 38'(RecipCyc);
  assign yoff1     = yr_prod1[CycShift +: YoffW];

  // ---------------------------------------------------------------------------
  // Stage 2: day of the year, hour and minute of the day.
  // ---------------------------------------------------------------------------
  logic             v2_q;
  logic             oor2_q;
  logic [DnumW-1:0] dnum2_q;
  logic [TodW-1:0]  tod2_q;
  logic [YoffW-1:0] yoff2_q;

  logic [5:0]       leap_days2;
  logic [DnumW-1:0] year_days2;
  logic [DnumW-1:0] doy_full2;
  logic [34:0]      hour_prod2;
  logic [34:0]      min_prod2;
  logic [4:0]       hour2;
  logic [MinTW-1:0] mint2;

  // Year n starts on day 365n + ceil(n / 4), since 1972 itself is a leap year.
  assign leap_days2 = 6'((8'(yoff2_q) + 8'd3) >> 2);
  assign year_days2 = DnumW'(yoff2_q) * DnumW'(DaysPerYear);
  assign doy_full2  = dnum2_q - year_days2 - DnumW'(leap_days2);
  assign hour_prod2 = 35'(tod2_q) * 35'(RecipHour);
  assign min_prod2  = 35'(tod2_q) * 35'(RecipMin);
  assign hour2      = hour_prod2[HourShift +: 5];
  assign mint2      = min_prod2[MinShift +: MinTW];

  // ---------------------------------------------------------------------------
  // Stage 3: month, day of month, minute and second; results are packed.
  // ---------------------------------------------------------------------------
  logic             v3_q;
  logic             oor3_q;
  logic [YoffW-1:0] yoff3_q;
  logic [DoyW-1:0]  doy3_q;
  logic [TodW-1:0]  tod3_q;
  logic [4:0]       hour3_q;
  logic [MinTW-1:0] mint3_q;

  uscf_md_t         md3;
  logic             leap3;
  logic [TodW-1:0]  sec_full3;
  logic [MinTW-1:0] min_full3;
  logic [6:0]       fat_yr3;
  uscf_res_t        res3;

  // The first year of every four-year cycle is the leap year.
  assign leap3 = (yoff3_q[1:0] == 2'b00);

  uscf_month_lookup u_month_lookup (
    .doy0_i (doy3_q),
    .leap_i (leap3),
    .md_o   (md3)
  );

  assign sec_full3 = tod3_q - TodW'(mint3_q) * TodW'(60);
  assign min_full3 = mint3_q - MinTW'(hour3_q) * MinTW'(60);
  // FAT years count from 1980; earlier years wrap in the seven year bits.
  assign fat_yr3   = yoff3_q - FatYearBias;

  always_comb begin
    res3          = '0;
    if (!oor3_q) begin
      res3.year     = BaseYear + 12'(yoff3_q);
      res3.month    = md3.month;
      res3.day      = md3.day;
      res3.hour     = hour3_q;
      res3.minute   = min_full3[5:0];
      res3.second   = sec_full3[5:0];
      res3.fat_date = {fat_yr3, md3.month, md3.day};
      res3.fat_time = {hour3_q, min_full3[5:0], sec_full3[5:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic      out_valid_q;
  logic      out_oor_q;
  uscf_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= s_axis_tvalid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q       <= s_axis_tdata_i;

      oor1_q    <= oor0;
      rel1_q    <= rel0[TodW-1:0];
      dnum1_q   <= dnum0;

      oor2_q    <= oor1_q;
      dnum2_q   <= dnum1_q;
      tod2_q    <= tod1;
      yoff2_q   <= yoff1;

      oor3_q    <= oor2_q;
      yoff3_q   <= yoff2_q;
      doy3_q    <= doy_full2[DoyW-1:0];
      tod3_q    <= tod2_q;
      hour3_q   <= hour2;
      mint3_q   <= mint2;

      out_oor_q <= oor3_q;
      res_q     <= res3;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q};
  assign m_axis_tuser_o  = out_oor_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_oor_q) |-> (res_q == '0))
    else $error("out-of-range result carries nonzero fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_oor_q) |->
      (res_q.year >= 12'd1972 && res_q.year <= 12'd2099 &&
       res_q.month >= 4'd1 && res_q.month <= 4'd12 &&
       res_q.day >= 5'd1 && res_q.day <= 5'd31))
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_oor_q) |->
      (res_q.hour <= 5'd23 && res_q.minute <= 6'd59 && res_q.second <= 6'd59))
    else $error("time of day out of range");

  a_february: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_oor_q && res_q.month == 4'd2) |->
      (res_q.day <= 5'd28 || (res_q.day == 5'd29 && res_q.year[1:0] == 2'b00)))
    else $error("February day beyond month length");

endmodule
